>>> rtl/ise_pkg.sv
package ise_pkg;
  typedef enum logic [2:0] {
    K_ADD = 3'd0, K_REMOVE = 3'd1, K_INTERSECT = 3'd2, K_CONTAINS = 3'd3,
    K_OVERLAPS = 3'd4, K_SHIFT = 3'd5, K_MIRROR = 3'd6, K_CLEAR = 3'd7
  } kind_t;

  typedef struct packed {
    logic [2:0]         kind;
    logic signed [31:0] range_low;
    logic signed [31:0] range_high;
    logic signed [31:0] offset;
  } req_t;

  typedef struct packed {
    logic               hit;
    logic               overflow;
    logic               range_error;
    logic [4:0]         interval_count;
    logic [32:0]        covered_total;
    logic signed [31:0] lowest_coord;
    logic signed [31:0] highest_coord;
  } rsp_t;

  // Token handed along the chain of cells
  typedef struct packed {
    logic               vld;
    logic signed [33:0] s;
    logic signed [33:0] e;
  } tok_t;

  // Per-pass control held in the engine for the whole request
  typedef struct packed {
    logic [2:0]         kind;
    logic signed [33:0] lo;
    logic signed [33:0] hi;
    logic signed [33:0] off;
  } pass_ctl_t;
endpackage

>>> rtl/ise_if.sv
interface ise_req_if;
  import ise_pkg::*;
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface ise_rsp_if;
  import ise_pkg::*;
  logic valid;
  logic ready;
  rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> rtl/interval_set_engine.sv
// Interval set engine: keeps up to CAPACITY sorted, disjoint, inclusive signed 32-bit
// intervals in a chain of cells with the head at cell 0, and serves one request at a
// time, returning one response per request. Each request rotates the chain once through
// the head, one entry a cycle, and builds the new list in a staging array. A second
// rotation then either reloads the chain from that list or restores it unchanged, and
// sums the covered total on the way. A request passes through an accept step, the pass,
// a step to close the list, the reload and a step to register the response; a new request
// is accepted only after that. A response still waiting stalls the engine only when the
// next response is ready to be registered.
module interval_set_engine #(
  parameter int CAPACITY = 16
) (
  input logic clk,
  input logic rst_n,
  ise_req_if.sink   in_req,
  ise_rsp_if.source out_rsp
);
  import ise_pkg::*;
  localparam int CW = $clog2(CAPACITY + 2);
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam logic [CW-1:0] CAP_C  = CW'(CAPACITY);
  localparam logic [CW-1:0] LAST_C = CW'(CAPACITY - 1);

  typedef enum logic [2:0] {S_IDLE, S_PASS, S_TAIL, S_LOAD, S_OUT} st_t;
  st_t st_r;

  // Staging list for the new table
  tok_t nw_r [CAPACITY];
  logic [CW-1:0] n_r, cnt_r, nn_r, fcnt_r;
  pass_ctl_t ctl_r;
  logic signed [33:0] lo_r, hi_r;
  logic placed_r, hit_r, ovf_r, rerr_r, commit_r;
  logic [32:0] tot_r;
  logic signed [31:0] lowc_r, highc_r;
  rsp_t rsp_r;
  logic ov_r;

  localparam logic signed [33:0] MIN32 = -34'sd2147483648;
  localparam logic signed [33:0] MAX32 = 34'sd2147483647;

  assign in_req.ready = (st_r == S_IDLE);
  assign out_rsp.valid = ov_r;
  assign out_rsp.data = rsp_r;

  // Chain cells: each cell shifts toward the head, the tail takes tail_in
  tok_t cin [CAPACITY];
  tok_t cout [CAPACITY];
  tok_t head, tail_in;
  logic shift_en;
  assign head = cout[0];

  genvar g;
  generate
    for (g = 0; g < CAPACITY; g++) begin : g_cell
      if (g == CAPACITY - 1) begin : g_last
        assign cin[g] = tail_in;
      end else begin : g_mid
        assign cin[g] = cout[g+1];
      end
      ise_cell u_cell (.clk(clk), .rst_n(rst_n), .load(shift_en),
                       .tok_in(cin[g]), .tok_out(cout[g]));
    end
  endgenerate

  // Chain rotates during the pass, and is reloaded or rotated back afterwards
  assign shift_en = (st_r == S_PASS) || (st_r == S_LOAD);

  always_comb begin
    tail_in = head;
    if (st_r == S_LOAD && commit_r) begin
      if (cnt_r < fcnt_r) tail_in = nw_r[cnt_r[AW-1:0]];
      else tail_in = '0;
    end
  end

  // Emit logic: up to two new entries per head entry
  logic e1, e2;
  logic signed [33:0] e1s, e1e, e2s, e2e;
  always_comb begin
    e1 = 1'b0; e2 = 1'b0;
    e1s = head.s; e1e = head.e; e2s = head.s; e2e = head.e;
    case (ctl_r.kind)
      K_ADD: begin
        if (head.e < lo_r - 34'sd1) begin
          e1 = 1'b1;
        end else if (head.s > hi_r + 34'sd1) begin
          if (!placed_r) begin
            e1 = 1'b1; e1s = lo_r; e1e = hi_r; e2 = 1'b1;
          end else begin
            e1 = 1'b1;
          end
        end
      end
      K_REMOVE: begin
        if (head.e < ctl_r.lo || head.s > ctl_r.hi) begin
          e1 = 1'b1;
        end else begin
          if (head.s < ctl_r.lo) begin
            e1 = 1'b1; e1e = ctl_r.lo - 34'sd1;
            if (head.e > ctl_r.hi) begin
              e2 = 1'b1; e2s = ctl_r.hi + 34'sd1;
            end
          end else if (head.e > ctl_r.hi) begin
            e1 = 1'b1; e1s = ctl_r.hi + 34'sd1;
          end
        end
      end
      K_INTERSECT: begin
        if (head.s <= ctl_r.hi && ctl_r.lo <= head.e) begin
          e1 = 1'b1;
          e1s = (head.s > ctl_r.lo) ? head.s : ctl_r.lo;
          e1e = (head.e < ctl_r.hi) ? head.e : ctl_r.hi;
        end
      end
      K_SHIFT: begin
        e1 = 1'b1; e1s = head.s + ctl_r.off; e1e = head.e + ctl_r.off;
      end
      K_MIRROR: begin
        e1 = 1'b1; e1s = ctl_r.off - head.e; e1e = ctl_r.off - head.s;
      end
      default: begin
      end
    endcase
  end

  // Write slots; a mirror fills the list from the far end
  logic [CW-1:0] wr1_idx, wr2_idx;
  assign wr1_idx = (ctl_r.kind == K_MIRROR) ? (n_r - cnt_r - 1'b1) : nn_r;
  assign wr2_idx = nn_r + 1'b1;

  // Decision once the pass is done
  logic [CW-1:0] nn_tail, fcnt_nxt;
  logic commit_nxt, ovf_nxt;
  always_comb begin
    nn_tail = nn_r + {{(CW-1){1'b0}}, (ctl_r.kind == K_ADD) && !placed_r};
    commit_nxt = 1'b0;
    ovf_nxt = 1'b0;
    fcnt_nxt = n_r;
    case (ctl_r.kind)
      K_ADD, K_REMOVE, K_INTERSECT: begin
        if (!rerr_r) begin
          if (nn_tail > CAP_C) begin
            ovf_nxt = 1'b1;
          end else begin
            commit_nxt = 1'b1; fcnt_nxt = nn_tail;
          end
        end
      end
      K_SHIFT, K_MIRROR: begin
        if (!rerr_r) begin
          commit_nxt = 1'b1; fcnt_nxt = nn_r;
        end
      end
      K_CLEAR: begin
        commit_nxt = 1'b1; fcnt_nxt = '0;
      end
      default: begin
      end
    endcase
  end

  logic rsp_load;
  assign rsp_load = (st_r == S_OUT) && (!ov_r || out_rsp.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      ov_r <= 1'b0;
      n_r  <= '0;
    end else begin
      if (rsp_load) ov_r <= 1'b1;
      else if (out_rsp.ready) ov_r <= 1'b0;
      case (st_r)
        S_IDLE: begin
          if (in_req.valid) begin
            ctl_r.kind <= in_req.data.kind;
            ctl_r.lo  <= 34'(in_req.data.range_low);
            ctl_r.hi  <= 34'(in_req.data.range_high);
            ctl_r.off <= 34'(in_req.data.offset);
            lo_r <= 34'(in_req.data.range_low);
            hi_r <= 34'(in_req.data.range_high);
            placed_r <= 1'b0; hit_r <= 1'b0;
            // reversed range for the range kinds
            rerr_r <= (in_req.data.kind <= K_OVERLAPS) &&
                      (in_req.data.range_low > in_req.data.range_high);
            nn_r <= '0; cnt_r <= '0;
            st_r <= S_PASS;
          end
        end
        S_PASS: begin
          if (cnt_r < n_r) begin
            if (ctl_r.kind == K_ADD && !e1) begin
              if (head.s < lo_r) lo_r <= head.s;
              if (head.e > hi_r) hi_r <= head.e;
            end
            if (ctl_r.kind == K_ADD && e2) placed_r <= 1'b1;
            if (ctl_r.kind == K_CONTAINS && !rerr_r &&
                head.s <= ctl_r.lo && ctl_r.hi <= head.e) hit_r <= 1'b1;
            if (ctl_r.kind == K_OVERLAPS && !rerr_r &&
                head.s <= ctl_r.hi && ctl_r.lo <= head.e) hit_r <= 1'b1;
            if (ctl_r.kind == K_SHIFT || ctl_r.kind == K_MIRROR) begin
              if (e1s < MIN32 || e1e > MAX32) rerr_r <= 1'b1;
            end
            if (e1 && wr1_idx < CAP_C)
              nw_r[wr1_idx[AW-1:0]] <= '{1'b1, e1s, e1e};
            if (e2 && wr2_idx < CAP_C)
              nw_r[wr2_idx[AW-1:0]] <= '{1'b1, e2s, e2e};
            nn_r <= nn_r + {{(CW-1){1'b0}}, e1} + {{(CW-1){1'b0}}, e2};
          end
          if (cnt_r == LAST_C) begin
            cnt_r <= '0;
            st_r <= S_TAIL;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        S_TAIL: begin
          // an add not yet placed goes at the end
          if (ctl_r.kind == K_ADD && !placed_r && nn_r < CAP_C)
            nw_r[nn_r[AW-1:0]] <= '{1'b1, lo_r, hi_r};
          commit_r <= commit_nxt;
          ovf_r <= ovf_nxt;
          fcnt_r <= fcnt_nxt;
          tot_r <= '0; lowc_r <= '0; highc_r <= '0;
          st_r <= S_LOAD;
        end
        S_LOAD: begin
          if (cnt_r < fcnt_r) begin
            tot_r <= tot_r + 33'(tail_in.e - tail_in.s + 34'sd1);
            if (cnt_r == '0) lowc_r <= tail_in.s[31:0];
            if (cnt_r + 1'b1 == fcnt_r) highc_r <= tail_in.e[31:0];
          end
          if (cnt_r == LAST_C) begin
            n_r <= fcnt_r;
            st_r <= S_OUT;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        S_OUT: begin
          if (rsp_load) begin
            rsp_r <= '{hit_r, ovf_r, rerr_r, 5'(n_r), tot_r, lowc_r, highc_r};
            st_r <= S_IDLE;
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  // Response held while it waits
  a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_rsp.valid && !out_rsp.ready |=> out_rsp.valid && $stable(out_rsp.data));
  // Stored count never above capacity
  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n) n_r <= CAP_C);
  // Overflow and range error never together
  a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_rsp.valid |-> !(out_rsp.data.overflow && out_rsp.data.range_error));
  // A hit comes only from a clean test
  a_hit_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_rsp.valid && out_rsp.data.hit |->
      !out_rsp.data.overflow && !out_rsp.data.range_error);
endmodule

>>> rtl/ise_cell.sv
// One stored interval slot; shifts its entry to the next cell when told
module ise_cell (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          load,
  input  ise_pkg::tok_t tok_in,
  output ise_pkg::tok_t tok_out
);
  import ise_pkg::*;
  tok_t q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r.vld <= 1'b0;
    end else if (load) begin
      q_r <= tok_in;
    end
  end

  assign tok_out = q_r;
endmodule

>>> tb/tb_ifs.sv
`timescale 1ns / 100ps
// Channel interfaces live with the RTL (ise_if.sv); nothing extra is needed here.
package tb_ifs_pkg;
  localparam int TB_CAPACITY = 16;
endpackage

>>> tb/tb.sv
`timescale 1ns / 100ps
module tb;
  import ise_pkg::*;
  import tb_ifs_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  bit failed = 1'b0;

  ise_req_if req_ch ();
  ise_rsp_if rsp_ch ();

  interval_set_engine #(.CAPACITY(TB_CAPACITY)) dut (
    .clk(clk), .rst_n(rst_n), .in_req(req_ch.sink), .out_rsp(rsp_ch.source)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow copy of the interval table, 64-bit so overflow checks are exact
  longint shadow_lo[TB_CAPACITY];
  longint shadow_hi[TB_CAPACITY];
  int shadow_n = 0;
  rsp_t pending_rsp[$];

  int send_idle_pct = 11;
  int recv_idle_pct = 56;

  // predict one request's response and update the shadow table
  function automatic rsp_t predict_interval_op(req_t r);
    rsp_t o;
    longint lo, hi, off, s, e, a, b;
    longint ns[$], ne[$];
    bit placed;
    o = '0;
    lo = r.range_low; hi = r.range_high; off = r.offset;
    placed = 0;
    if (r.kind <= K_OVERLAPS && lo > hi) begin
      o.range_error = 1;
    end else begin
      case (kind_t'(r.kind))
        K_ADD: begin
          for (int i = 0; i < shadow_n; i++) begin
            s = shadow_lo[i]; e = shadow_hi[i];
            if (e < lo - 1) begin
              ns = {ns, s}; ne = {ne, e};
            end else if (s > hi + 1) begin
              if (!placed) begin ns = {ns, lo}; ne = {ne, hi}; placed = 1; end
              ns = {ns, s}; ne = {ne, e};
            end else begin
              if (s < lo) lo = s;
              if (e > hi) hi = e;
            end
          end
          if (!placed) begin ns = {ns, lo}; ne = {ne, hi}; end
        end
        K_REMOVE: begin
          for (int i = 0; i < shadow_n; i++) begin
            s = shadow_lo[i]; e = shadow_hi[i];
            if (e < lo || s > hi) begin
              ns = {ns, s}; ne = {ne, e};
            end else begin
              if (s < lo) begin ns = {ns, s}; ne = {ne, lo - 1}; end
              if (e > hi) begin ns = {ns, hi + 1}; ne = {ne, e}; end
            end
          end
        end
        K_INTERSECT: begin
          for (int i = 0; i < shadow_n; i++) begin
            s = shadow_lo[i]; e = shadow_hi[i];
            if (s <= hi && lo <= e) begin
              ns = {ns, (s > lo ? s : lo)}; ne = {ne, (e < hi ? e : hi)};
            end
          end
        end
        K_CONTAINS:
          for (int i = 0; i < shadow_n; i++)
            if (shadow_lo[i] <= lo && hi <= shadow_hi[i]) o.hit = 1;
        K_OVERLAPS:
          for (int i = 0; i < shadow_n; i++)
            if (shadow_lo[i] <= hi && lo <= shadow_hi[i]) o.hit = 1;
        K_SHIFT:
          if (shadow_n > 0) begin
            a = shadow_lo[0] + off; b = shadow_hi[shadow_n-1] + off;
            if (a < -64'sd2147483648 || b > 64'sd2147483647) o.range_error = 1;
            else for (int i = 0; i < shadow_n; i++) begin
              shadow_lo[i] += off; shadow_hi[i] += off;
            end
          end
        K_MIRROR:
          if (shadow_n > 0) begin
            a = off - shadow_hi[shadow_n-1]; b = off - shadow_lo[0];
            if (a < -64'sd2147483648 || b > 64'sd2147483647) o.range_error = 1;
            else for (int i = 0; i < shadow_n; i++) begin
              ns = {ns, off - shadow_hi[shadow_n-1-i]};
              ne = {ne, off - shadow_lo[shadow_n-1-i]};
            end
          end
        K_CLEAR: shadow_n = 0;
        default: ;
      endcase
      // list-producing kinds commit only if the result fits
      if (r.kind <= K_INTERSECT ||
          (r.kind == K_MIRROR && shadow_n > 0 && !o.range_error)) begin
        if (ns.size() > TB_CAPACITY) o.overflow = 1;
        else begin
          foreach (ns[i]) begin shadow_lo[i] = ns[i]; shadow_hi[i] = ne[i]; end
          shadow_n = ns.size();
        end
      end
    end
    o.interval_count = 5'(shadow_n);
    o.covered_total = '0;
    for (int i = 0; i < shadow_n; i++)
      o.covered_total += 33'(shadow_hi[i] - shadow_lo[i] + 1);
    if (shadow_n > 0) begin
      o.lowest_coord = 32'(shadow_lo[0]);
      o.highest_coord = 32'(shadow_hi[shadow_n-1]);
    end
    return o;
  endfunction

  // drive one request from a falling edge, holding it until accepted
  task automatic send_request(req_t r, bit typed, rsp_t typed_rsp);
    rsp_t p;
    do @(negedge clk); while ($urandom_range(99) < send_idle_pct);
    req_ch.valid <= 1'b1;
    req_ch.data <= r;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    p = predict_interval_op(r);
    if (typed && p != typed_rsp) begin
      $display("%0t table row disagrees: expected %h actual %h", $time, typed_rsp, p);
      failed = 1;
    end
    pending_rsp = {pending_rsp, p};
    @(negedge clk);
    req_ch.valid <= 1'b0;
  endtask

  function automatic req_t mk(kind_t k, int lo, int hi, int off);
    req_t r;
    r.kind = k; r.range_low = lo; r.range_high = hi; r.offset = off;
    return r;
  endfunction

  // random coordinate: mostly a small window so requests interact
  function automatic int rnd_coord();
    case ($urandom_range(9))
      0: return $urandom;
      1: return $urandom_range(1) ? 32'sh7fffffff - $urandom_range(40)
                                  : 32'sh80000000 + $urandom_range(40);
      default: return int'($urandom_range(200)) - 100;
    endcase
  endfunction

  function automatic req_t rnd_request();
    req_t r;
    int a, b, t;
    a = rnd_coord();
    b = ($urandom_range(3) == 0) ? rnd_coord() : a + int'($urandom_range(12));
    if ($urandom_range(19) != 0 && a > b) begin t = a; a = b; b = t; end
    r.kind = ($urandom_range(29) == 0) ? K_CLEAR : 3'($urandom_range(6));
    r.range_low = a; r.range_high = b;
    r.offset = ($urandom_range(4) == 0) ? $urandom : int'($urandom_range(60)) - 30;
    return r;
  endfunction

  // response checker
  always @(posedge clk) begin
    rsp_t exp_rsp;
    if (rst_n && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_rsp.size() == 0) begin
        $display("%0t unexpected response: actual %h", $time, rsp_ch.data);
        failed = 1;
      end else begin
        exp_rsp = pending_rsp.pop_front();
        if (rsp_ch.data.hit !== exp_rsp.hit ||
            rsp_ch.data.overflow !== exp_rsp.overflow ||
            rsp_ch.data.range_error !== exp_rsp.range_error ||
            rsp_ch.data.interval_count !== exp_rsp.interval_count ||
            rsp_ch.data.covered_total !== exp_rsp.covered_total ||
            rsp_ch.data.lowest_coord !== exp_rsp.lowest_coord ||
            rsp_ch.data.highest_coord !== exp_rsp.highest_coord) begin
          $display("%0t response mismatch: expected %h actual %h",
                   $time, exp_rsp, rsp_ch.data);
          failed = 1;
        end
      end
    end
  end

  // receiver backpressure
  always @(negedge clk)
    rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);

  typedef struct {
    req_t r;
    bit   typed;
    rsp_t o;
  } stim_row_t;

  stim_row_t rows[$];

  function automatic rsp_t mkr(bit h, bit ov, bit re, int n, longint tot, int lo, int hi);
    rsp_t o;
    o.hit = h; o.overflow = ov; o.range_error = re; o.interval_count = 5'(n);
    o.covered_total = 33'(tot); o.lowest_coord = lo; o.highest_coord = hi;
    return o;
  endfunction

  // append one row to the stimulus table
  task automatic add_row(req_t r, bit typed, rsp_t o);
    stim_row_t row;
    row.r = r; row.typed = typed; row.o = o;
    rows = {rows, row};
  endtask

  initial begin
    req_ch.valid = 1'b0;
    req_ch.data = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed table
    add_row(mk(K_CONTAINS, 0, 0, 0), 1, mkr(0,0,0,0,0,0,0));
    add_row(mk(K_SHIFT, 0, 0, 32'sh7fffffff), 1, mkr(0,0,0,0,0,0,0));
    add_row(mk(K_ADD, 5, 4, 0), 1, mkr(0,0,1,0,0,0,0));
    add_row(mk(K_ADD, 32'sh80000000, 32'sh7fffffff, 0), 1,
            mkr(0,0,0,1,64'h100000000,32'sh80000000,32'sh7fffffff));
    add_row(mk(K_SHIFT, 0, 0, 1), 1,
            mkr(0,0,1,1,64'h100000000,32'sh80000000,32'sh7fffffff));
    add_row(mk(K_MIRROR, 0, 0, 0), 1,
            mkr(0,0,1,1,64'h100000000,32'sh80000000,32'sh7fffffff));
    add_row(mk(K_REMOVE, 0, 0, 0), 1,
            mkr(0,0,0,2,64'hffffffff,32'sh80000000,32'sh7fffffff));
    add_row(mk(K_OVERLAPS, 0, 0, 0), 1,
            mkr(0,0,0,2,64'hffffffff,32'sh80000000,32'sh7fffffff));
    add_row(mk(K_CONTAINS, -9, -1, 0), 1,
            mkr(1,0,0,2,64'hffffffff,32'sh80000000,32'sh7fffffff));
    add_row(mk(K_ADD, 0, 0, 0), 0, '0);   // closes the gap again
    add_row(mk(K_CLEAR, 0, 0, 0), 1, mkr(0,0,0,0,0,0,0));
    for (int i = 0; i < 17; i++)            // seventeenth entry overflows
      add_row(mk(K_ADD, 4*i, 4*i+1, 0), 0, '0);
    add_row(mk(K_REMOVE, 0, 0, 0), 0, '0);
    add_row(mk(K_INTERSECT, 9, 9, 0), 0, '0);  // point member
    add_row(mk(K_SHIFT, 0, 0, -5), 0, '0);
    add_row(mk(K_MIRROR, 0, 0, 32'sh80000000), 0, '0);
    add_row(mk(K_INTERSECT, 7, 7, 0), 0, '0);  // not a member: empties
    foreach (rows[i]) send_request(rows[i].r, rows[i].typed, rows[i].o);

    // random phases: idling swapped between the first two, no idling in the last
    for (int ph = 0; ph < 3; ph++) begin
      if (ph == 1) begin send_idle_pct = 56; recv_idle_pct = 11; end
      if (ph == 2) begin send_idle_pct = 0; recv_idle_pct = 0; end
      for (int i = 0; i < 207; i++) begin
        if (i == 100) wait (pending_rsp.size() == 0);
        send_request(rnd_request(), 0, '0);
      end
    end

    wait (pending_rsp.size() == 0);
    repeat (60) @(posedge clk);
    if (!failed) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

  initial begin
    #20ms;
    $display("status: fail");
    $finish;
  end
endmodule
